// ----- rtl/core/image_conv_3x3_stream_core_macros.svh -----
// ----------------------------------------------------------------------------
// image_conv_3x3_stream_core_macros
// assertion shorthands used by the convolution core
// ----------------------------------------------------------------------------
`ifndef IMAGE_CONV_3X3_STREAM_CORE_MACROS_SVH
`define IMAGE_CONV_3X3_STREAM_CORE_MACROS_SVH

// same-cycle implication
`define ICV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ICV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/icv_pkg.sv -----
// ----------------------------------------------------------------------------
// icv_pkg
// shared constants and types of the 3x3 streaming convolution core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package icv_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WD_W  = $clog2(MAX_WIDTH + 1);
  localparam int HT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int DIM_W = 11;
  localparam int NCH_W = 2;

  localparam int WIN     = 3;
  localparam int NCH     = 3;
  localparam int PIX_W   = 8;
  localparam int PIXEL_W = NCH * PIX_W;
  localparam int COEF_W  = 16;
  localparam int PROD_W  = PIX_W + COEF_W;
  localparam int CSUM_W  = PROD_W + 2;
  localparam int TSUM_W  = CSUM_W + 2;
  localparam int OUT_W   = 29;
  localparam int POS_W   = 10;
  localparam int KROW_W  = WIN * COEF_W;

  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = PIXEL_W;
  localparam int OUT_PAY_W   = NCH * OUT_W + 2 * POS_W;
  localparam int OUT_TDATA_W = ((OUT_PAY_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_CHANNELS      = 3'd2,
    REG_PRESERVE      = 3'd3,
    REG_KERNEL_TOP    = 3'd4,
    REG_KERNEL_MID    = 3'd5,
    REG_KERNEL_BOTTOM = 3'd6
  } cfg_reg_t;

  typedef logic [PIXEL_W-1:0]       pixel_t;
  typedef pixel_t [WIN-1:0]         win_col_t;   // [0] top row, [2] bottom row
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [WIN-1:0]          coef_col_t;
  typedef logic signed [CSUM_W-1:0] csum_t;
  typedef csum_t [NCH-1:0]          csum_ch_t;
  typedef logic signed [OUT_W-1:0]  res_t;

  typedef struct packed {
    logic shift;       // take the column from the right-hand neighbor
    logic load_prod;   // product stage may load
    logic load_sum;    // column sum stage may load
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/image_conv_3x3_stream_core.sv -----
// ----------------------------------------------------------------------------
// image_conv_3x3_stream_core
// streaming 3x3 convolution, valid region only, one pixel per clock
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                       request when
//  s_*       in   pix_ch0, pix_ch1, pix_ch2                     tvalid & tready
//  m_*       out  out_ch0..2, out_col, out_row, frame_end=tlast tvalid & tready
//  cfg_*     in   register index, write data                    valid & ready
//
//  one pixel per clock while m_tready does not stall the pipeline; each result is registered at the output
//  the rate is set by the line store ports: one read and one write per pixel
//  pipeline: entry/ram read, window shift, products, column sums, totals, output
//  every stage holds on its own; a bubble anywhere lets the input keep flowing
//  reset clears counters, valid bits and configuration registers; line stores need no clearing
//  cfg_ready is always high; writes are meant for an idle core
//
`timescale 1ns / 1ps
`default_nettype none

`include "image_conv_3x3_stream_core_macros.svh"

module image_conv_3x3_stream_core
  import icv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // pixel request
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,    // pix_ch0, pix_ch1, pix_ch2
  // result request
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,    // out_ch0, out_ch1, out_ch2, out_col, out_row, pad
  output logic                   m_tlast,    // frame_end
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [KROW_W-1:0]      cfg_data
);

  localparam int NSTG    = 6;      // entry, window, product, column sum, total, output
  localparam int MIN_DIM = WIN;
  localparam int RST_DIM = 1024;

  typedef struct packed {
    logic [POS_W-1:0] ocol;
    logic [POS_W-1:0] orow;
    logic             fend;
  } pos_t;

  function automatic logic [WD_W-1:0] clamp_width(input logic [DIM_W-1:0] raw);
    int v;
    v = int'(raw);
    if (v < MIN_DIM) begin
      v = MIN_DIM;
    end else if (v > MAX_WIDTH) begin
      v = MAX_WIDTH;
    end
    return WD_W'(v);
  endfunction

  function automatic logic [HT_W-1:0] clamp_height(input logic [DIM_W-1:0] raw);
    int v;
    v = int'(raw);
    if (v < MIN_DIM) begin
      v = MIN_DIM;
    end else if (v > MAX_HEIGHT) begin
      v = MAX_HEIGHT;
    end
    return HT_W'(v);
  endfunction

  // --------------------------------------------------------------------------
  // configuration, kept in its clamped form
  // --------------------------------------------------------------------------
  logic              cfg_fire;
  logic [WD_W-1:0]   w_eff;
  logic [HT_W-1:0]   h_eff;
  logic [NCH_W-1:0]  nch_eff;
  logic              preserve;
  logic [KROW_W-1:0] kernel_row [WIN];

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff      <= clamp_width(DIM_W'(RST_DIM));
      h_eff      <= clamp_height(DIM_W'(RST_DIM));
      nch_eff    <= NCH_W'(NCH);
      preserve   <= 1'b0;
      kernel_row <= '{default: '0};
    end else if (cfg_fire) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:   w_eff <= clamp_width(cfg_data[DIM_W-1:0]);
        REG_IMAGE_HEIGHT:  h_eff <= clamp_height(cfg_data[DIM_W-1:0]);
        REG_CHANNELS: begin
          // zero channels acts as one
          nch_eff <= (cfg_data[NCH_W-1:0] == '0) ? NCH_W'(1) : cfg_data[NCH_W-1:0];
        end
        REG_PRESERVE:      preserve      <= cfg_data[0];
        REG_KERNEL_TOP:    kernel_row[0] <= cfg_data;
        REG_KERNEL_MID:    kernel_row[1] <= cfg_data;
        REG_KERNEL_BOTTOM: kernel_row[2] <= cfg_data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline handshake: each stage loads when it is empty or moving on
  // --------------------------------------------------------------------------
  logic [NSTG:1] vld;
  logic [NSTG:1] rdy;
  logic          in_fire;
  logic          move1;

  always_comb begin
    rdy[NSTG] = !vld[NSTG] || m_tready;
    for (int i = NSTG - 1; i >= 1; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign s_tready = rdy[1];
  assign in_fire  = s_tvalid && rdy[1];
  assign move1    = vld[1] && rdy[2];
  assign m_tvalid = vld[NSTG];

  // --------------------------------------------------------------------------
  // raster position of the incoming pixel
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] col_count, col_count_next, cur_col;
  logic [ROW_W-1:0] row_count, row_count_next, cur_row;
  logic             col_wrap;
  logic [HT_W-1:0]  row_step, row_inc;
  logic [WD_W-1:0]  col_inc;
  logic             make_res;
  pos_t             entry_pos;

  always_comb begin
    // a shrunk geometry wraps a stale position before use
    col_wrap = WD_W'(col_count) >= w_eff;
    cur_col  = col_wrap ? '0 : col_count;
    row_step = HT_W'(row_count) + HT_W'(col_wrap);
    cur_row  = (row_step >= h_eff) ? '0 : ROW_W'(row_step);

    col_inc = WD_W'(cur_col) + WD_W'(1);
    row_inc = HT_W'(cur_row) + HT_W'(1);
    if (col_inc >= w_eff) begin
      col_count_next = '0;
      row_count_next = (row_inc >= h_eff) ? '0 : ROW_W'(row_inc);
    end else begin
      col_count_next = COL_W'(col_inc);
      row_count_next = cur_row;
    end

    // a full window exists once two columns and two rows lie behind the pixel
    make_res       = (cur_col >= COL_W'(WIN - 1)) && (cur_row >= ROW_W'(WIN - 1));
    entry_pos.ocol = POS_W'(cur_col - COL_W'(WIN - 1));
    entry_pos.orow = POS_W'(cur_row - ROW_W'(WIN - 1));
    entry_pos.fend = (WD_W'(cur_col) == w_eff - WD_W'(1)) &&
                     (HT_W'(cur_row) == h_eff - HT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_fire) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // --------------------------------------------------------------------------
  // entry stage and line stores; store reads land with the entry registers
  // --------------------------------------------------------------------------
  pixel_t           pix1;
  logic [COL_W-1:0] col1;
  logic             make1;
  pixel_t           a_rd, b_rd;
  pos_t             pos [NSTG:1];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      pix1   <= pixel_t'(s_tdata);
      col1   <= cur_col;
      make1  <= make_res;
      pos[1] <= entry_pos;
    end
    for (int i = 2; i <= NSTG; i++) begin
      if (rdy[i]) begin
        pos[i] <= pos[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= s_tvalid;
      end
      // pixels with no full window still shift the window but end here
      if (rdy[2]) begin
        vld[2] <= vld[1] && make1;
      end
      for (int i = 3; i <= NSTG; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // row above
  icv_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) line_store_a (
    .clk     (clk),
    .wr_en   (move1),
    .wr_addr (col1),
    .wr_data (pix1),
    .rd_en   (in_fire),
    .rd_addr (cur_col),
    .rd_data (a_rd)
  );

  // row two above, fed from the row above as it is overwritten
  icv_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) line_store_b (
    .clk     (clk),
    .wr_en   (move1),
    .wr_addr (col1),
    .wr_data (a_rd),
    .rd_en   (in_fire),
    .rd_addr (cur_col),
    .rd_data (b_rd)
  );

  // --------------------------------------------------------------------------
  // window: three column cells, the new column enters at the right
  // --------------------------------------------------------------------------
  win_col_t            new_col;
  win_col_t            col_link  [WIN];
  coef_col_t           coef_cols [WIN];
  csum_ch_t [WIN-1:0]  csum_all;
  cell_ctl_t           cell_ctl;
  res_t [NCH-1:0]      res;

  assign new_col[0] = b_rd;
  assign new_col[1] = a_rd;
  assign new_col[2] = pix1;

  assign cell_ctl.shift     = move1;
  assign cell_ctl.load_prod = rdy[3];
  assign cell_ctl.load_sum  = rdy[4];

  // kernel column k sits at bits 16k+15:16k of each row register
  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      for (int r = 0; r < WIN; r++) begin
        coef_cols[k][r] = kernel_row[r][k*COEF_W +: COEF_W];
      end
    end
  end

  for (genvar k = 0; k < WIN; k++) begin : g_cell
    icv_cell u_cell (
      .clk     (clk),
      .ctl     (cell_ctl),
      .col_in  ((k == WIN - 1) ? new_col : col_link[(k + 1) % WIN]),
      .coef    (coef_cols[k]),
      .col_out (col_link[k]),
      .csum    (csum_all[k])
    );
  end

  icv_combine u_combine (
    .clk      (clk),
    .ld_total (rdy[5]),
    .ld_out   (rdy[6]),
    .preserve (preserve),
    .nch      (nch_eff),
    .csum     (csum_all),
    .res      (res)
  );

  // --------------------------------------------------------------------------
  // result packing
  // --------------------------------------------------------------------------
  assign m_tdata = OUT_TDATA_W'({pos[NSTG].orow, pos[NSTG].ocol, res[2], res[1], res[0]});
  assign m_tlast = pos[NSTG].fend;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  `ICV_ASSERT_NOW(a_store_rw_apart, clk, rst, move1 && in_fire, col1 != cur_col,
    "line store read and write hit the same column")
  `ICV_ASSERT_NEXT(a_col_in_range, clk, rst, in_fire && !cfg_fire, WD_W'(col_count) < w_eff,
    "column counter left the row")
  `ICV_ASSERT_NEXT(a_total_reaches_out, clk, rst, vld[5] && rdy[6], m_tvalid,
    "finished total did not reach the output register")

endmodule

`default_nettype wire

// ----- rtl/core/icv_ram.sv -----
// ----------------------------------------------------------------------------
// icv_ram
// generic simple dual-port ram, one write port, registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module icv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/icv_cell.sv -----
// ----------------------------------------------------------------------------
// icv_cell
// one window column: holds three pixels, passes them left, forms the
// column's weighted sum for every channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module icv_cell
  import icv_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  win_col_t  col_in,
  input  coef_col_t coef,
  output win_col_t  col_out,
  output csum_ch_t  csum
);

  win_col_t                 pix;
  logic signed [PROD_W:0]   prod_full [NCH][WIN];
  logic signed [PROD_W-1:0] prod      [NCH][WIN];
  csum_ch_t                 csum_next;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      pix <= col_in;
    end
  end

  assign col_out = pix;

  // 8-bit unsigned sample times signed q8.8 coefficient
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      for (int r = 0; r < WIN; r++) begin
        prod_full[ch][r] = $signed({1'b0, pix[r][ch*PIX_W +: PIX_W]}) * $signed(coef[r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      for (int ch = 0; ch < NCH; ch++) begin
        for (int r = 0; r < WIN; r++) begin
          prod[ch][r] <= prod_full[ch][r][PROD_W-1:0];
        end
      end
    end
  end

  always_comb begin
    logic signed [CSUM_W-1:0] acc;
    for (int ch = 0; ch < NCH; ch++) begin
      acc = '0;
      for (int r = 0; r < WIN; r++) begin
        acc = acc + CSUM_W'(prod[ch][r]);
      end
      csum_next[ch] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_sum) begin
      csum <= csum_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/icv_combine.sv -----
// ----------------------------------------------------------------------------
// icv_combine
// adds the column sums of the window and applies the channel mode
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module icv_combine
  import icv_pkg::*;
(
  input  logic                   clk,
  input  logic                   ld_total,
  input  logic                   ld_out,
  input  logic                   preserve,
  input  logic [NCH_W-1:0]       nch,
  input  csum_ch_t [WIN-1:0]     csum,
  output res_t [NCH-1:0]         res
);

  logic signed [TSUM_W-1:0] total      [NCH];
  logic signed [TSUM_W-1:0] total_next [NCH];
  res_t [NCH-1:0]           res_next;

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      total_next[ch] = '0;
      for (int k = 0; k < WIN; k++) begin
        total_next[ch] = total_next[ch] + TSUM_W'($signed(csum[k][ch]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_total) begin
      total <= total_next;
    end
  end

  // channels at or above nch give nothing; summing mode folds into channel 0
  always_comb begin
    logic signed [OUT_W-1:0] acc;
    logic signed [OUT_W-1:0] ext;
    acc = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      ext = OUT_W'(total[ch]);
      if (NCH_W'(ch) < nch) begin
        acc          = acc + ext;
        res_next[ch] = preserve ? ext : '0;
      end else begin
        res_next[ch] = '0;
      end
    end
    if (!preserve) begin
      res_next[0] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire
